>>> rtl/i2cmts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Shared types, codes and sizes for the transfer sequencer block.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

	localparam int MAX_MESSAGE_BYTES_DEF = 64;
	localparam int CFG_DATA_W            = 16;
	localparam int CFG_INDEX_W           = 3;
	localparam int MAX_RESULTS           = 3;

	typedef enum logic [3:0] {
		OP_START      = 4'd0,
		OP_START_SENT = 4'd1,
		OP_ADDR_ACKED = 4'd2,
		OP_BYTE_DONE  = 4'd3,
		OP_BYTE_RX    = 4'd4,
		OP_TX_EMPTY   = 4'd5,
		OP_ACK_FAIL   = 4'd6,
		OP_DMA        = 4'd7,
		OP_TIMEOUT    = 4'd8
	} op_t;

	typedef enum logic [3:0] {
		ACT_START      = 4'd0,
		ACT_STOP       = 4'd1,
		ACT_SEND       = 4'd2,
		ACT_ACK_ON     = 4'd3,
		ACT_BUF_ON     = 4'd4,
		ACT_BUF_OFF    = 4'd5,
		ACT_DMA_RX     = 4'd6,
		ACT_DMA_RX_ONE = 4'd7,
		ACT_STORE      = 4'd8,
		ACT_DONE       = 4'd9,
		ACT_NONE       = 4'd10
	} action_t;

	localparam logic [1:0] ST_ACK     = 2'd0;
	localparam logic [1:0] ST_NACK    = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_SLAVE_ADDRESS  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_READ_DIRECTION = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_USE_REG_ADDR   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_REG_ADDR_WIDE  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_REG_ADDR       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MESSAGE_LENGTH = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT    = 3'd6;

	typedef struct packed {
		logic [6:0]  slave_address;
		logic        read_direction;
		logic        use_register_address;
		logic        register_address_wide;
		logic [15:0] register_address;
		logic [6:0]  message_length;
		logic [2:0]  retry_limit;
	} cfg_t;

	typedef struct packed {
		logic [3:0] operation;
		logic       transmitter_flag;
		logic [7:0] data_byte;
		logic       dma_error;
		logic       dma_complete;
	} item_t;

	typedef struct packed {
		logic       busy;
		logic       reg_pending;
		logic [6:0] position;
		logic [2:0] retries_left;
		logic [1:0] status;
	} seq_state_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] byte_value;
		logic [6:0] byte_index;
		logic [1:0] transfer_status;
		logic       last;
	} result_t;

	typedef result_t [MAX_RESULTS-1:0] bundle_t;

	function automatic result_t mk_result(action_t act, logic [7:0] value,
			logic [6:0] index, logic [1:0] status);
		result_t r;
		r.action          = act;
		r.byte_value      = value;
		r.byte_index      = index;
		r.transfer_status = status;
		r.last            = 1'b0;
		return r;
	endfunction

endpackage

>>> rtl/i2cmts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer channel interfaces
// Valid/ready channels for controller events in and bus actions out.
// ----------------------------------------------------------------------------
interface i2cmts_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] operation;
	logic       transmitter_flag;
	logic [7:0] data_byte;
	logic       dma_error;
	logic       dma_complete;

	modport source (output valid, operation, transmitter_flag, data_byte,
		dma_error, dma_complete, input ready);
	modport sink (input valid, operation, transmitter_flag, data_byte,
		dma_error, dma_complete, output ready);
endinterface

interface i2cmts_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] action;
	logic [7:0] byte_value;
	logic [6:0] byte_index;
	logic [1:0] transfer_status;
	logic       last;

	modport source (output valid, action, byte_value, byte_index,
		transfer_status, last, input ready);
	modport sink (input valid, action, byte_value, byte_index,
		transfer_status, last, output ready);
endinterface

>>> rtl/i2cmts_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer step logic
// Works out the next state and up to three bus actions for one event.
// ----------------------------------------------------------------------------
module i2cmts_step #(
	parameter int MAX_MESSAGE_BYTES = i2cmts_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  i2cmts_pkg::cfg_t       cfg,
	input  i2cmts_pkg::seq_state_t st,
	input  i2cmts_pkg::item_t      item,
	output i2cmts_pkg::seq_state_t st_next,
	output i2cmts_pkg::bundle_t    results,
	output logic [1:0]             count
);
	import i2cmts_pkg::*;

	localparam logic [7:0] MAX_B = MAX_MESSAGE_BYTES[7:0];

	logic [7:0] len8;
	logic [6:0] len;
	logic       tx_phase;
	logic [6:0] pos_inc;
	logic       pos_ok;
	seq_state_t nxt;
	bundle_t    res;
	logic [1:0] n;

	always_comb begin
		len8 = {1'b0, cfg.message_length};
		if (len8 == 8'd0) begin
			len8 = 8'd1;
		end
		if (len8 > MAX_B) begin
			len8 = MAX_B;
		end
		len = len8[6:0];
	end

	assign tx_phase = !cfg.read_direction || st.reg_pending;
	assign pos_ok   = st.position < len;
	assign pos_inc  = st.position + 7'd1;

	always_comb begin
		nxt = st;
		res = '0;
		n   = 2'd0;
		if (item.operation == OP_START) begin
			nxt.busy         = 1'b1;
			nxt.position     = 7'd0;
			nxt.retries_left = cfg.retry_limit;
			nxt.status       = ST_ACK;
			nxt.reg_pending  = cfg.use_register_address;
			res[0] = mk_result(ACT_BUF_OFF, 8'd0, 7'd0, 2'd0);
			res[1] = mk_result(ACT_START, 8'd0, 7'd0, 2'd0);
			n = 2'd2;
		end else if (st.busy) begin
			case (item.operation)
				OP_START_SENT: begin
					nxt.position = 7'd0;
					if (tx_phase) begin
						res[0] = mk_result(ACT_SEND, {cfg.slave_address, 1'b0}, 7'd0, 2'd0);
						n = 2'd1;
					end else begin
						res[0] = mk_result(ACT_ACK_ON, 8'd0, 7'd0, 2'd0);
						res[1] = mk_result(ACT_SEND, {cfg.slave_address, 1'b1}, 7'd0, 2'd0);
						n = 2'd2;
					end
				end
				OP_ADDR_ACKED: begin
					if (tx_phase) begin
						if (st.reg_pending) begin
							if (cfg.register_address_wide) begin
								res[n] = mk_result(ACT_SEND, cfg.register_address[15:8],
									7'd0, 2'd0);
								n = n + 2'd1;
							end
							res[n] = mk_result(ACT_SEND, cfg.register_address[7:0], 7'd0, 2'd0);
							n = n + 2'd1;
							nxt.reg_pending = 1'b0;
						end
						res[n] = mk_result(ACT_BUF_ON, 8'd0, 7'd0, 2'd0);
						n = n + 2'd1;
					end else begin
						res[0] = mk_result((len == 7'd1) ? ACT_DMA_RX_ONE : ACT_DMA_RX,
							8'd0, len, 2'd0);
						n = 2'd1;
					end
				end
				OP_BYTE_DONE: begin
					if (item.transmitter_flag) begin
						if (cfg.read_direction) begin
							res[0] = mk_result(ACT_START, 8'd0, 7'd0, 2'd0);
							n = 2'd1;
						end else begin
							res[0] = mk_result(ACT_DONE, 8'd0, 7'd0, st.status);
							res[1] = mk_result(ACT_STOP, 8'd0, 7'd0, 2'd0);
							n = 2'd2;
							nxt.busy = 1'b0;
						end
					end else if (pos_ok) begin
						res[0] = mk_result(ACT_STORE, item.data_byte, st.position, 2'd0);
						n = 2'd1;
						nxt.position = pos_inc;
						if (pos_inc == len) begin
							res[1] = mk_result(ACT_DONE, 8'd0, 7'd0, st.status);
							res[2] = mk_result(ACT_STOP, 8'd0, 7'd0, 2'd0);
							n = 2'd3;
							nxt.busy = 1'b0;
						end
					end
				end
				OP_BYTE_RX: begin
					if (pos_ok) begin
						res[0] = mk_result(ACT_STORE, item.data_byte, st.position, 2'd0);
						n = 2'd1;
						nxt.position = pos_inc;
						if (pos_inc == len) begin
							res[1] = mk_result(ACT_BUF_OFF, 8'd0, 7'd0, 2'd0);
							n = 2'd2;
						end
					end
				end
				OP_TX_EMPTY: begin
					if (cfg.read_direction || !pos_ok) begin
						res[0] = mk_result(ACT_BUF_OFF, 8'd0, 7'd0, 2'd0);
						n = 2'd1;
					end else begin
						res[0] = mk_result(ACT_SEND, item.data_byte, st.position, 2'd0);
						n = 2'd1;
						nxt.position = pos_inc;
						if (pos_inc == len) begin
							res[1] = mk_result(ACT_BUF_OFF, 8'd0, 7'd0, 2'd0);
							n = 2'd2;
						end
					end
				end
				OP_ACK_FAIL: begin
					if (st.retries_left != 3'd0) begin
						nxt.retries_left = st.retries_left - 3'd1;
						res[0] = mk_result(ACT_START, 8'd0, 7'd0, 2'd0);
						n = 2'd1;
					end else begin
						nxt.status = ST_NACK;
						res[0] = mk_result(ACT_DONE, 8'd0, 7'd0, ST_NACK);
						res[1] = mk_result(ACT_STOP, 8'd0, 7'd0, 2'd0);
						n = 2'd2;
						nxt.busy = 1'b0;
					end
				end
				OP_DMA: begin
					if (item.dma_error) begin
						nxt.status = ST_NACK;
					end else if (item.dma_complete) begin
						nxt.status = ST_ACK;
					end
					res[0] = mk_result(ACT_DONE, 8'd0, 7'd0, nxt.status);
					res[1] = mk_result(ACT_STOP, 8'd0, 7'd0, 2'd0);
					n = 2'd2;
					nxt.busy = 1'b0;
				end
				OP_TIMEOUT: begin
					// The bus gets reinitialized outside, so no stop follows.
					nxt.status = ST_TIMEOUT;
					res[0] = mk_result(ACT_DONE, 8'd0, 7'd0, ST_TIMEOUT);
					n = 2'd1;
					nxt.busy = 1'b0;
				end
				default: begin
				end
			endcase
		end
		if (n != 2'd0) begin
			res[n - 2'd1].last = 1'b1;
		end
	end

	assign st_next = nxt;
	assign results = res;
	assign count   = n;

endmodule

>>> rtl/i2cmts_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer result buffer
// Holds the actions of one event and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module i2cmts_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  i2cmts_pkg::bundle_t bundle,
	input  logic [1:0]          count,
	output logic                can_load,
	i2cmts_out_if.source        res
);
	import i2cmts_pkg::*;

	bundle_t    res_q;
	logic [1:0] cnt_q;
	logic       hs;

	assign hs       = res.valid && res.ready;
	assign can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && hs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= count;
		end else if (hs) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= bundle;
		end else if (hs) begin
			res_q <= {result_t'('0), res_q[MAX_RESULTS-1:1]};
		end
	end

	assign res.valid           = cnt_q != 2'd0;
	assign res.action          = res_q[0].action;
	assign res.byte_value      = res_q[0].byte_value;
	assign res.byte_index      = res_q[0].byte_index;
	assign res.transfer_status = res_q[0].transfer_status;
	assign res.last            = res_q[0].last;

	// The final beat of an event carries the last mark, and no earlier one does.
	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		hs && cnt_q == 2'd1 |-> res_q[0].last)
		else $error("final beat of an event lacks last");
	a_no_early_last: assert property (@(posedge clk) disable iff (!arst_n)
		hs && cnt_q > 2'd1 |-> !res_q[0].last)
		else $error("last set before the final beat");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load && !can_load |=> 1'b0)
		else $error("result bundle loaded over pending beats");

endmodule

>>> rtl/i2c_master_transfer_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Turns byte-level controller events into the bus actions of one message.
// ----------------------------------------------------------------------------
// Channel     Dir  Beat
// bus_event   in   one controller event (operation, flags, data byte)
// bus_action  out  one bus action (action, byte, index, status, last)
// wr_*        in   register write, index and data, no handshake
//
// An event is registered on entry and resolved combinationally into up to
// three actions, which the result buffer hands out one per cycle while
// bus_action is ready. A new event is taken every cycle while events cause
// at most one action and bus_action is ready; else it waits for the buffer.
// Events that cause no action just update state. Reset clears state and
// restores register defaults; a stalled output holds the input register.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_top #(
	parameter int MAX_MESSAGE_BYTES = i2cmts_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [i2cmts_pkg::CFG_INDEX_W-1:0]   wr_index,
	input  logic [i2cmts_pkg::CFG_DATA_W-1:0]    wr_data,
	i2cmts_in_if.sink                            bus_event,
	i2cmts_out_if.source                         bus_action
);
	import i2cmts_pkg::*;

	cfg_t       cfg_q;
	seq_state_t st_q;
	seq_state_t st_next;
	item_t      item_s1;
	logic       v_s1;
	bundle_t    bundle;
	logic [1:0] n_res;
	logic       can_load;
	logic       fire;
	logic       load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address         <= 7'd0;
			cfg_q.read_direction        <= 1'b0;
			cfg_q.use_register_address  <= 1'b0;
			cfg_q.register_address_wide <= 1'b0;
			cfg_q.register_address      <= 16'd0;
			cfg_q.message_length        <= 7'd1;
			cfg_q.retry_limit           <= 3'd2;
		end else if (wr_en) begin
			case (wr_index)
				REG_SLAVE_ADDRESS:  cfg_q.slave_address         <= wr_data[6:0];
				REG_READ_DIRECTION: cfg_q.read_direction        <= wr_data[0];
				REG_USE_REG_ADDR:   cfg_q.use_register_address  <= wr_data[0];
				REG_REG_ADDR_WIDE:  cfg_q.register_address_wide <= wr_data[0];
				REG_REG_ADDR:       cfg_q.register_address      <= wr_data;
				REG_MESSAGE_LENGTH: cfg_q.message_length        <= wr_data[6:0];
				REG_RETRY_LIMIT:    cfg_q.retry_limit           <= wr_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// The registered event moves on once the result buffer can take its actions.
	assign fire            = v_s1 && can_load;
	assign load            = fire && (n_res != 2'd0);
	assign bus_event.ready = !v_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (bus_event.ready) begin
			v_s1 <= bus_event.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bus_event.ready && bus_event.valid) begin
			item_s1.operation        <= bus_event.operation;
			item_s1.transmitter_flag <= bus_event.transmitter_flag;
			item_s1.data_byte        <= bus_event.data_byte;
			item_s1.dma_error        <= bus_event.dma_error;
			item_s1.dma_complete     <= bus_event.dma_complete;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_next;
		end
	end

	i2cmts_step #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_step (
		.cfg     (cfg_q),
		.st      (st_q),
		.item    (item_s1),
		.st_next (st_next),
		.results (bundle),
		.count   (n_res)
	);

	i2cmts_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.bundle   (bundle),
		.count    (n_res),
		.can_load (can_load),
		.res      (bus_action)
	);

	// Events other than start are silent while no message is open.
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !st_q.busy && item_s1.operation != OP_START |-> n_res == 2'd0)
		else $error("idle event produced actions");
	// The retry count only grows when a message starts.
	a_retry_down: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.operation != OP_START |=>
		st_q.retries_left <= $past(st_q.retries_left))
		else $error("retry count grew without a start");
	// A start always opens a message and queues two actions.
	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.operation == OP_START |-> n_res == 2'd2 && st_next.busy)
		else $error("start did not open a message");

endmodule
